>>> rtl/add_sub_paren_expression_evaluator_core_defines.svh
// ----------------------------------------------------------------------------
// assertion macros for the add/sub parenthesis evaluator
// concurrent checks sampled on the rising clock edge, disabled during reset
// ----------------------------------------------------------------------------
`ifndef ADD_SUB_PAREN_EXPRESSION_EVALUATOR_CORE_DEFINES_SVH
`define ADD_SUB_PAREN_EXPRESSION_EVALUATOR_CORE_DEFINES_SVH

// same-cycle implication
`define ASPE_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASPE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/aspe_pkg.sv
// ----------------------------------------------------------------------------
// aspe_pkg
// shared types, constants and the character decoder of the evaluator
// ----------------------------------------------------------------------------
package aspe_pkg;

	localparam int VALUE_BITS = 32;
	localparam int MAX_NEST   = 16;
	localparam int LEVEL_BITS = $clog2(MAX_NEST + 1);
	localparam int ADDR_BITS  = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNBAL = 2'd1,
		ST_DEEP  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CLS_DIGIT,
		CLS_PLUS,
		CLS_MINUS,
		CLS_OPEN,
		CLS_CLOSE,
		CLS_OTHER
	} char_class_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} in_beat_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] value;
		status_t                      status;
	} out_beat_t;

	// one stack entry: saved sign and saved sum
	typedef struct packed {
		logic                  minus;
		logic [VALUE_BITS-1:0] sum;
	} stack_entry_t;

	// state after the last character, before the final fold
	typedef struct packed {
		logic [VALUE_BITS-1:0] sum;
		logic [VALUE_BITS-1:0] num;
		logic                  minus;
		logic                  open_left;
		status_t               err;
	} snap_t;

	function automatic char_class_t char_class(input logic [7:0] c);
		char_class_t cls;
		if (c inside {[CH_ZERO:CH_NINE]}) begin
			cls = CLS_DIGIT;
		end else begin
			case (c)
				CH_PLUS:  cls = CLS_PLUS;
				CH_MINUS: cls = CLS_MINUS;
				CH_OPEN:  cls = CLS_OPEN;
				CH_CLOSE: cls = CLS_CLOSE;
				default:  cls = CLS_OTHER;
			endcase
		end
		return cls;
	endfunction

endpackage

>>> rtl/add_sub_paren_expression_evaluator_core.sv
// ----------------------------------------------------------------------------
// add_sub_paren_expression_evaluator_core
// streaming evaluator for decimal sums and differences with parentheses
// ----------------------------------------------------------------------------
// one character beat is taken per clock, back to back, and the character
// stream of one expression ends with the beat marked last_char; that beat
// yields a single result beat (wrapping 32-bit value plus status) once it
// has passed the snapshot register and the queue; the next expression may
// follow at once. the rate of one character per cycle is set by the nesting
// stack: its ram always prefetches the entry below the next nest level, and a
// push that lands on the entry being prefetched is forwarded, so a ')' straight
// after a '(' costs nothing. the stack ram needs no clearing pass after reset.
// a result queue of two beats sits in front of the output, so character beats
// keep flowing while a result waits; input stalls only while two results are
// pending and the output side is not taking one in that cycle.
// digits, '+', '-', '(' and ')' are decoded, every other byte is skipped and
// does not end a number. errors (unbalanced or too deep nesting) are sticky
// for the rest of the expression and report value zero.
// ----------------------------------------------------------------------------
module add_sub_paren_expression_evaluator_core import aspe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_beat,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_beat
);

	// handshake on the character side
	logic  take;
	// state snapshot of a finished expression
	snap_t snap;
	logic  snap_valid;
	// result queue has space for one more expression
	logic  room;

	assign in_ready = room;
	assign take     = in_valid && in_ready;

	// character decode, running sum and ram-based nesting stack
	aspe_eval u_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.beat      (in_beat),
		.snap      (snap),
		.snap_valid(snap_valid)
	);

	// last fold, status and output queue
	aspe_result u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.snap      (snap),
		.snap_valid(snap_valid),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_beat  (out_beat)
	);

endmodule

>>> rtl/aspe_stack_ram.sv
// ----------------------------------------------------------------------------
// aspe_stack_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module aspe_stack_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 33
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read-first: a same-address write is forwarded by the user
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

>>> rtl/aspe_eval.sv
// ----------------------------------------------------------------------------
// aspe_eval
// per-character state update with the nesting stack held in ram
// ----------------------------------------------------------------------------
module aspe_eval import aspe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     take,
	input  in_beat_t beat,
	output snap_t    snap,
	output logic     snap_valid
);

	logic [VALUE_BITS-1:0] sum_q, num_q;
	logic                  minus_q;
	logic [LEVEL_BITS-1:0] level_q;
	status_t               err_q;
	logic                  fwd_hit_q;
	stack_entry_t          fwd_data_q;

	logic [VALUE_BITS-1:0] n_sum, n_num, num_x10, folded, popped;
	logic                  n_minus;
	logic [LEVEL_BITS-1:0] n_level, upd_level, rd_level;
	status_t               n_err;
	char_class_t           cls;
	logic [7:0]            digit_off;
	logic                  push;
	logic [ADDR_BITS-1:0]  wr_addr, rd_addr;
	stack_entry_t          wr_entry, rd_entry, top;

	aspe_stack_ram #(
		.DEPTH(MAX_NEST),
		.WIDTH(VALUE_BITS + 1)
	) u_ram (
		.clk    (clk),
		.wr_en  (take && push),
		.wr_addr(wr_addr),
		.wr_data(wr_entry),
		.rd_addr(rd_addr),
		.rd_data(rd_entry)
	);

	// top of stack, prefetched in the cycle before; a forwarded push wins over the ram
	assign top = fwd_hit_q ? fwd_data_q : rd_entry;

	always_comb begin
		cls       = char_class(beat.char_code);
		digit_off = beat.char_code - CH_ZERO;
		num_x10   = (num_q << 3) + (num_q << 1) + VALUE_BITS'(digit_off[3:0]);
		folded    = minus_q ? sum_q - num_q : sum_q + num_q;
		popped    = top.minus ? top.sum - folded : top.sum + folded;

		n_sum   = sum_q;
		n_num   = num_q;
		n_minus = minus_q;
		n_level = level_q;
		n_err   = err_q;
		push    = 1'b0;

		if (err_q == ST_OK) begin
			case (cls)
				CLS_DIGIT: begin
					n_num = num_x10;
				end
				CLS_PLUS, CLS_MINUS: begin
					n_sum   = folded;
					n_num   = '0;
					n_minus = (cls == CLS_MINUS);
				end
				CLS_OPEN: begin
					n_sum = folded;
					n_num = '0;
					if (level_q >= LEVEL_BITS'(MAX_NEST)) begin
						n_err = ST_DEEP;
					end else begin
						push    = 1'b1;
						n_level = level_q + LEVEL_BITS'(1);
						n_sum   = '0;
						n_minus = 1'b0;
					end
				end
				CLS_CLOSE: begin
					n_sum = folded;
					n_num = '0;
					if (level_q == '0) begin
						n_err = ST_UNBAL;
					end else begin
						n_level = level_q - LEVEL_BITS'(1);
						n_sum   = popped;
						n_minus = top.minus;
					end
				end
				default: begin
				end
			endcase
		end

		wr_addr  = level_q[ADDR_BITS-1:0];
		wr_entry = '{minus: minus_q ? 1'b1 : 1'b0, sum: folded};
		wr_entry.minus = minus_q;

		// level after this cycle decides which entry is on top next cycle
		if (!take) begin
			upd_level = level_q;
		end else if (beat.last_char) begin
			upd_level = '0;
		end else begin
			upd_level = n_level;
		end
		rd_level = upd_level - LEVEL_BITS'(1);
		rd_addr  = rd_level[ADDR_BITS-1:0];

		snap.sum       = n_sum;
		snap.num       = n_num;
		snap.minus     = n_minus;
		snap.open_left = (n_level != '0);
		snap.err       = n_err;
		snap_valid     = take && beat.last_char;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			num_q     <= '0;
			minus_q   <= 1'b0;
			level_q   <= '0;
			err_q     <= ST_OK;
			fwd_hit_q <= 1'b0;
		end else begin
			fwd_hit_q <= take && push && (wr_addr == rd_addr);
			if (take) begin
				if (beat.last_char) begin
					sum_q   <= '0;
					num_q   <= '0;
					minus_q <= 1'b0;
					level_q <= '0;
					err_q   <= ST_OK;
				end else begin
					sum_q   <= n_sum;
					num_q   <= n_num;
					minus_q <= n_minus;
					level_q <= n_level;
					err_q   <= n_err;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= wr_entry;
	end

endmodule

>>> rtl/aspe_result.sv
// ----------------------------------------------------------------------------
// aspe_result
// final fold of the pending number, status decision and a two-deep result queue
// ----------------------------------------------------------------------------
module aspe_result import aspe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  snap_t     snap,
	input  logic      snap_valid,
	output logic      room,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_beat
);

	localparam int QDEPTH = 2;
	localparam int CBITS  = $clog2(QDEPTH + 1);
	localparam int PBITS  = $clog2(QDEPTH);

	snap_t                 snap_s1;
	logic                  valid_s1;
	out_beat_t             ent_q [QDEPTH];
	logic [CBITS-1:0]      count_q, occ;
	logic [PBITS-1:0]      rd_ptr_q, wr_ptr_q;
	logic [VALUE_BITS-1:0] folded;
	out_beat_t             fin;
	logic                  pop;

	always_comb begin
		folded = snap_s1.minus ? snap_s1.sum - snap_s1.num : snap_s1.sum + snap_s1.num;
		if (snap_s1.err != ST_OK) begin
			fin.value  = '0;
			fin.status = snap_s1.err;
		end else if (snap_s1.open_left) begin
			fin.value  = '0;
			fin.status = ST_UNBAL;
		end else begin
			fin.value  = signed'(folded);
			fin.status = ST_OK;
		end
	end

	assign out_valid = (count_q != '0);
	assign out_beat  = ent_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign occ       = count_q + CBITS'(valid_s1);
	assign room      = (occ != CBITS'(QDEPTH)) || pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			count_q  <= '0;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
		end else begin
			valid_s1 <= snap_valid;
			if (valid_s1) begin
				wr_ptr_q <= wr_ptr_q + PBITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PBITS'(1);
			end
			count_q <= count_q + CBITS'(valid_s1) - CBITS'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (snap_valid) begin
			snap_s1 <= snap;
		end
		if (valid_s1) begin
			ent_q[wr_ptr_q] <= fin;
		end
	end

endmodule

>>> rtl/aspe_checker.sv
// ----------------------------------------------------------------------------
// aspe_checker
// port-level checks of the evaluator, bound to the top level
// ----------------------------------------------------------------------------
`include "add_sub_paren_expression_evaluator_core_defines.svh"

module aspe_checker import aspe_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_beat_t  in_beat,
	input logic      out_valid,
	input logic      out_ready,
	input out_beat_t out_beat
);

	// a stalled result beat stays put
	`ASPE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_beat), "result beat changed while stalled")

	// an error result never carries a value
	`ASPE_ASSERT_SAME(a_err_zero, clk, arst_n, out_valid && (out_beat.status != ST_OK), out_beat.value == '0, "error result with non-zero value")

	// with the output side empty the block takes characters
	`ASPE_ASSERT_SAME(a_ready_idle, clk, arst_n, !out_valid, in_ready, "input stalled with no result pending")

	// a last beat taken while the output is empty shows up once it has passed the snapshot and queue registers
	`ASPE_ASSERT_NEXT(a_last_result, clk, arst_n, in_valid && in_ready && in_beat.last_char && !out_valid, ##1 out_valid, "result missing after last character")

endmodule

bind add_sub_paren_expression_evaluator_core aspe_checker u_aspe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.in_beat  (in_beat),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_beat (out_beat)
);
